// File: design/hpack_field_representation_parser_defines.svh
// ---------------------------------------------------------------------------
// HPACK field parser assertion macros
// Concurrent assertion forms used by the parser decoder.
// ---------------------------------------------------------------------------
`ifndef HPACK_FIELD_REPRESENTATION_PARSER_DEFINES_SVH
`define HPACK_FIELD_REPRESENTATION_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hfp_pkg.sv
// ---------------------------------------------------------------------------
// HPACK field parser package
// Token codes, parser phases and the structs passed between the stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfp_pkg;

  localparam int VALUE_W = 32;

  // Representation kind reported with every token.
  typedef enum logic [2:0] {
    KIND_INDEXED     = 3'd0,
    KIND_SIZE_UPDATE = 3'd1,
    KIND_INCREMENTAL = 3'd2,
    KIND_WITHOUT_IDX = 3'd3,
    KIND_NEVER_IDX   = 3'd4
  } kind_t;

  // Token type.
  typedef enum logic [2:0] {
    ITEM_INDEX      = 3'd0,
    ITEM_NAME_LEN   = 3'd1,
    ITEM_NAME_BYTE  = 3'd2,
    ITEM_VALUE_LEN  = 3'd3,
    ITEM_VALUE_BYTE = 3'd4,
    ITEM_ERROR      = 3'd5
  } item_t;

  // Error code carried by error tokens.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_TRUNC    = 2'd2
  } err_t;

  // Parser position inside a representation.
  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_IDX_CONT   = 3'd1,
    PH_NLEN_FIRST = 3'd2,
    PH_NLEN_CONT  = 3'd3,
    PH_NAME_DATA  = 3'd4,
    PH_VLEN_FIRST = 3'd5,
    PH_VLEN_CONT  = 3'd6,
    PH_VALUE_DATA = 3'd7
  } phase_t;

  // One input byte of the header block.
  typedef struct packed {
    logic [7:0] byte_req;
    logic       block_end;
  } hfp_byte_t;

  // One output token.
  typedef struct packed {
    kind_t               kind;
    item_t               item;
    logic [VALUE_W-1:0]  value;
    logic                huffman;
    logic [7:0]          data_byte;
    logic                last;
    err_t                error;
  } hfp_token_t;

endpackage

// File: design/hfp_in_stage.sv
// ---------------------------------------------------------------------------
// HPACK field parser input stage
// Registers one header byte and hands it to the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hfp_pkg::hfp_byte_t in_data,
  input  logic              adv,
  output logic              s_valid,
  output hfp_pkg::hfp_byte_t s_data
);

  logic               valid_r;
  logic               valid_nxt;
  hfp_pkg::hfp_byte_t data_r;
  logic               load;
  logic               take;

  // The held item leaves when the decoder steps; a new one may enter in the same cycle.
  assign take     = valid_r && adv;
  assign in_ready = !valid_r || adv;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign s_valid = valid_r;
  assign s_data  = data_r;

endmodule

// File: design/hfp_decoder.sv
// ---------------------------------------------------------------------------
// HPACK field parser decoder
// Classifies representations, accumulates prefixed integers and tracks
// string lengths; produces at most one token for each byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hpack_field_representation_parser_defines.svh"

module hfp_decoder #(
  parameter int INT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  input  hfp_pkg::hfp_byte_t  s_data,
  input  logic                adv,
  output logic                tok_fire,
  output hfp_pkg::hfp_token_t tok
);

  localparam int ACC_W = (INT_WIDTH >= 32) ? 32 : INT_WIDTH;
  // A nonzero 7-bit group shifted by at most 31, plus a carry.
  localparam int SUM_W = 39;

  hfp_pkg::phase_t     phase_r, phase_step, phase_nxt;
  hfp_pkg::kind_t      kind_r, kind_nxt, kind_start, kind_cur;
  logic [ACC_W-1:0]    acc_r, acc_nxt, acc_add, bl_r, bl_nxt, bl_dec, int_val;
  logic [5:0]          shift_r, shift_nxt, shift_sat;
  logic [6:0]          shift_sum;
  logic                huff_r, huff_nxt, huff_cur;
  logic                hold_r, hold_nxt;

  logic [7:0]          b;
  logic                blk_end;
  logic                step;
  logic [6:0]          start_v;
  logic                start_full;
  logic                len_full;
  logic [6:0]          chunk;
  logic [SUM_W-1:0]    acc_ext, shifted, sum;
  logic                ovf_raw, ovf_ev;
  logic                is_cont, is_idx, is_name;
  logic                int_fire;
  logic                kind_short;
  hfp_pkg::phase_t     done_phase;
  logic                trunc;
  logic                tok_valid;
  logic [hfp_pkg::VALUE_W-1:0] int_val32;

  assign b       = s_data.byte_req;
  assign blk_end = s_data.block_end;
  assign step    = s_valid && adv;

  // First byte of a representation: kind and integer prefix.
  always_comb begin
    start_v    = 7'd0;
    start_full = 1'b0;
    priority if (b[7]) begin
      kind_start = hfp_pkg::KIND_INDEXED;
      start_v    = b[6:0];
      start_full = (b[6:0] == 7'h7f);
    end else if (b[6]) begin
      kind_start = hfp_pkg::KIND_INCREMENTAL;
      start_v    = {1'b0, b[5:0]};
      start_full = (b[5:0] == 6'h3f);
    end else if (b[5]) begin
      kind_start = hfp_pkg::KIND_SIZE_UPDATE;
      start_v    = {2'b0, b[4:0]};
      start_full = (b[4:0] == 5'h1f);
    end else if (b[4]) begin
      kind_start = hfp_pkg::KIND_NEVER_IDX;
      start_v    = {3'b0, b[3:0]};
      start_full = (b[3:0] == 4'hf);
    end else begin
      kind_start = hfp_pkg::KIND_WITHOUT_IDX;
      start_v    = {3'b0, b[3:0]};
      start_full = (b[3:0] == 4'hf);
    end
  end

  assign kind_cur   = (phase_r == hfp_pkg::PH_START) ? kind_start : kind_r;
  assign kind_short = (kind_cur == hfp_pkg::KIND_INDEXED) ||
                      (kind_cur == hfp_pkg::KIND_SIZE_UPDATE);
  assign len_full   = (b[6:0] == 7'h7f);
  assign huff_cur   = ((phase_r == hfp_pkg::PH_NLEN_FIRST) ||
                       (phase_r == hfp_pkg::PH_VLEN_FIRST)) ? b[7] : huff_r;

  // Continuation byte: shift-add of one 7-bit group with overflow check.
  assign chunk   = b[6:0];
  always_comb begin
    acc_ext             = '0;
    acc_ext[ACC_W-1:0]  = acc_r;
    shifted             = SUM_W'(chunk) << shift_r[4:0];
    sum                 = acc_ext + shifted;
  end
  assign ovf_raw   = shift_r[5] || (|sum[SUM_W-1:ACC_W]);
  assign acc_add   = (chunk != 7'd0) ? sum[ACC_W-1:0] : acc_r;
  assign shift_sum = {1'b0, shift_r} + 7'd7;
  assign shift_sat = shift_sum[6] ? 6'd63 : shift_sum[5:0];

  assign is_cont = (phase_r == hfp_pkg::PH_IDX_CONT) ||
                   (phase_r == hfp_pkg::PH_NLEN_CONT) ||
                   (phase_r == hfp_pkg::PH_VLEN_CONT);
  assign is_idx  = (phase_r == hfp_pkg::PH_START) || (phase_r == hfp_pkg::PH_IDX_CONT);
  assign is_name = (phase_r == hfp_pkg::PH_NLEN_FIRST) || (phase_r == hfp_pkg::PH_NLEN_CONT);
  assign ovf_ev  = !hold_r && is_cont && (chunk != 7'd0) && ovf_raw;

  // Completed integer and the place it leads to.
  always_comb begin
    int_val  = '0;
    int_fire = 1'b0;
    if (phase_r == hfp_pkg::PH_START) begin
      int_val[6:0] = start_v;
      int_fire     = !start_full;
    end else if ((phase_r == hfp_pkg::PH_NLEN_FIRST) ||
                 (phase_r == hfp_pkg::PH_VLEN_FIRST)) begin
      int_val[6:0] = b[6:0];
      int_fire     = !len_full;
    end else if (is_cont) begin
      int_val  = acc_add;
      int_fire = !ovf_ev && !b[7];
    end
  end

  always_comb begin
    int_val32              = '0;
    int_val32[ACC_W-1:0]   = int_val;
  end

  always_comb begin
    if (is_idx) begin
      if (kind_short) begin
        done_phase = hfp_pkg::PH_START;
      end else if (int_val == '0) begin
        done_phase = hfp_pkg::PH_NLEN_FIRST;
      end else begin
        done_phase = hfp_pkg::PH_VLEN_FIRST;
      end
    end else if (is_name) begin
      done_phase = (int_val != '0) ? hfp_pkg::PH_NAME_DATA : hfp_pkg::PH_VLEN_FIRST;
    end else begin
      done_phase = (int_val != '0) ? hfp_pkg::PH_VALUE_DATA : hfp_pkg::PH_START;
    end
  end

  assign bl_dec = (bl_r != '0) ? (bl_r - ACC_W'(1)) : bl_r;

  // Next state.
  always_comb begin
    phase_step = phase_r;
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    shift_nxt  = shift_r;
    bl_nxt     = bl_r;
    huff_nxt   = huff_r;
    hold_nxt   = hold_r;
    if (hold_r) begin
      // Dropping bytes after an overflow until the block ends.
      if (blk_end) begin
        hold_nxt   = 1'b0;
        phase_step = hfp_pkg::PH_START;
      end
    end else begin
      unique case (phase_r)
        hfp_pkg::PH_START: begin
          kind_nxt = kind_start;
          if (start_full) begin
            acc_nxt        = '0;
            acc_nxt[6:0]   = start_v;
            shift_nxt      = 6'd0;
            phase_step     = hfp_pkg::PH_IDX_CONT;
          end else begin
            phase_step = done_phase;
          end
        end
        hfp_pkg::PH_NLEN_FIRST, hfp_pkg::PH_VLEN_FIRST: begin
          huff_nxt = b[7];
          if (len_full) begin
            acc_nxt      = '0;
            acc_nxt[6:0] = 7'h7f;
            shift_nxt    = 6'd0;
            phase_step   = (phase_r == hfp_pkg::PH_NLEN_FIRST) ?
                           hfp_pkg::PH_NLEN_CONT : hfp_pkg::PH_VLEN_CONT;
          end else begin
            phase_step = done_phase;
            bl_nxt     = int_val;
          end
        end
        hfp_pkg::PH_IDX_CONT, hfp_pkg::PH_NLEN_CONT, hfp_pkg::PH_VLEN_CONT: begin
          if (ovf_ev) begin
            phase_step = hfp_pkg::PH_START;
            hold_nxt   = !blk_end;
          end else begin
            acc_nxt = acc_add;
            if (b[7]) begin
              shift_nxt = shift_sat;
            end else begin
              phase_step = done_phase;
              if (!is_idx) begin
                bl_nxt = int_val;
              end
            end
          end
        end
        hfp_pkg::PH_NAME_DATA: begin
          bl_nxt = bl_dec;
          if (bl_dec == '0) begin
            phase_step = hfp_pkg::PH_VLEN_FIRST;
          end
        end
        hfp_pkg::PH_VALUE_DATA: begin
          bl_nxt = bl_dec;
          if (bl_dec == '0) begin
            phase_step = hfp_pkg::PH_START;
          end
        end
      endcase
    end
  end

  // A block that ends inside a representation restarts the parser.
  assign trunc     = !hold_r && blk_end && (phase_step != hfp_pkg::PH_START);
  assign phase_nxt = trunc ? hfp_pkg::PH_START : phase_step;

  // Token for this byte.
  always_comb begin
    tok_valid     = 1'b0;
    tok.kind      = kind_cur;
    tok.item      = hfp_pkg::ITEM_INDEX;
    tok.value     = '0;
    tok.huffman   = 1'b0;
    tok.data_byte = 8'd0;
    tok.last      = 1'b0;
    tok.error     = hfp_pkg::ERR_NONE;
    if (!hold_r) begin
      unique case (phase_r)
        hfp_pkg::PH_NAME_DATA: begin
          tok_valid     = 1'b1;
          tok.item      = hfp_pkg::ITEM_NAME_BYTE;
          tok.data_byte = b;
        end
        hfp_pkg::PH_VALUE_DATA: begin
          tok_valid     = 1'b1;
          tok.item      = hfp_pkg::ITEM_VALUE_BYTE;
          tok.data_byte = b;
          tok.last      = (bl_dec == '0);
        end
        default: begin
          if (ovf_ev) begin
            tok_valid = 1'b1;
            tok.item  = hfp_pkg::ITEM_ERROR;
            tok.last  = 1'b1;
            tok.error = hfp_pkg::ERR_OVERFLOW;
          end else if (int_fire) begin
            tok_valid = 1'b1;
            tok.value = int_val32;
            if (is_idx) begin
              tok.item = hfp_pkg::ITEM_INDEX;
              tok.last = kind_short;
            end else if (is_name) begin
              tok.item    = hfp_pkg::ITEM_NAME_LEN;
              tok.huffman = huff_cur;
            end else begin
              tok.item    = hfp_pkg::ITEM_VALUE_LEN;
              tok.huffman = huff_cur;
              tok.last    = (int_val == '0);
            end
          end
        end
      endcase
      if (trunc) begin
        tok_valid     = 1'b1;
        tok.item      = hfp_pkg::ITEM_ERROR;
        tok.value     = '0;
        tok.huffman   = 1'b0;
        tok.data_byte = 8'd0;
        tok.last      = 1'b1;
        tok.error     = hfp_pkg::ERR_TRUNC;
      end
    end
  end

  assign tok_fire = step && tok_valid;

  // Parser state, advanced once per byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hfp_pkg::PH_START;
      kind_r  <= hfp_pkg::KIND_INDEXED;
      acc_r   <= '0;
      shift_r <= 6'd0;
      bl_r    <= '0;
      huff_r  <= 1'b0;
      hold_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      bl_r    <= bl_nxt;
      huff_r  <= huff_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // Error tokens always close a representation.
  `HFP_ASSERT_NOW(a_err_closes, clk, rst_n, tok_fire && (tok.error != hfp_pkg::ERR_NONE), tok.last && (tok.item == hfp_pkg::ITEM_ERROR), "error token without last")
  // While bytes are being dropped the parser waits at a representation start.
  `HFP_ASSERT_NOW(a_hold_start, clk, rst_n, hold_r, phase_r == hfp_pkg::PH_START, "drop mode outside representation start")
  // An overflow before the block end enters drop mode.
  `HFP_ASSERT_NEXT(a_ovf_hold, clk, rst_n, step && ovf_ev && !blk_end, hold_r, "overflow did not enter drop mode")

endmodule

// File: design/hfp_out_reg.sv
// ---------------------------------------------------------------------------
// HPACK field parser output register
// Holds one token until the receiver takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_fire,
  input  hfp_pkg::hfp_token_t tok,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output hfp_pkg::hfp_token_t out_tok
);

  logic                valid_r;
  logic                valid_nxt;
  hfp_pkg::hfp_token_t tok_r;

  // The decoder may step whenever this register is empty or is being emptied.
  assign adv = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (tok_fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_fire) begin
      tok_r <= tok;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule

// File: design/hpack_field_representation_parser.sv
// ---------------------------------------------------------------------------
// HPACK header field representation parser
// Streams an encoded header block one byte per item and emits tokens.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel takes one byte of the header block per item, with
//   in_block_end set on the final byte. The output channel returns zero or
//   one token per byte: index or table size, string lengths with their
//   Huffman flag, raw string bytes, or an error token (integer overflow or
//   block truncated inside a representation).
//   Both channels use valid/ready. A byte passes through an input register
//   and is decoded into an output register, which presents its token.
//   One byte is taken every cycle while the receiver does not stall the
//   output register; the integer shift-add, length countdown and token
//   selection fit between those two registers.
//   When the receiver stalls, the output register holds its token and the
//   input register holds the next byte, after which in_ready drops.
//   Synchronous reset (rst_n low) empties both registers and returns the
//   parser to the start of a representation with drop mode cleared.
//   INT_WIDTH (16..64) sets the integer limit, min(INT_WIDTH, 32) bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpack_field_representation_parser #(
  parameter int INT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_req,
  input  logic        in_block_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_item,
  output logic [31:0] out_value,
  output logic        out_huffman,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  output logic [1:0]  out_error
);

  hfp_pkg::hfp_byte_t  in_data;
  hfp_pkg::hfp_byte_t  s_data;
  hfp_pkg::hfp_token_t tok;
  hfp_pkg::hfp_token_t out_tok;
  logic                s_valid;
  logic                adv;
  logic                tok_fire;

  assign in_data.byte_req  = in_byte_req;
  assign in_data.block_end = in_block_end;

  // Input register.
  hfp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .s_valid  (s_valid),
    .s_data   (s_data)
  );

  // Representation decoder and parser state.
  hfp_decoder #(
    .INT_WIDTH (INT_WIDTH)
  ) u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (s_valid),
    .s_data   (s_data),
    .adv      (adv),
    .tok_fire (tok_fire),
    .tok      (tok)
  );

  // Output register.
  hfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_fire  (tok_fire),
    .tok       (tok),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign out_kind      = out_tok.kind;
  assign out_item      = out_tok.item;
  assign out_value     = out_tok.value;
  assign out_huffman   = out_tok.huffman;
  assign out_data_byte = out_tok.data_byte;
  assign out_last      = out_tok.last;
  assign out_error     = out_tok.error;

endmodule

// File: test/hfp_token_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// HPACK field parser token scoreboard
// Predicts the token that each accepted header byte produces and checks
// the parser's output tokens against them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfp_token_scoreboard_pkg;

  import hfp_pkg::*;

  class token_scoreboard;

    // Shadow copy of the parser state.
    phase_t      parse_phase;
    kind_t       cur_kind;
    logic [31:0] accum;
    logic [5:0]  shift_cnt;
    logic [31:0] bytes_left;
    logic        str_huffman;
    bit          dropping;

    // Tokens predicted but not yet seen on the output.
    hfp_token_t  expected_tokens[$];

    int bytes_parsed;
    int bytes_dropped;
    int tokens_checked;
    int overflow_tokens;
    int trunc_tokens;
    int mismatches;

    function new();
      parse_phase = PH_START;
      cur_kind    = KIND_INDEXED;
      accum       = '0;
      shift_cnt   = '0;
      bytes_left  = '0;
      str_huffman = 1'b0;
      dropping    = 1'b0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function hfp_token_t make_token(item_t it, logic [31:0] val, logic huff,
                                    logic [7:0] data, logic lst, err_t err);
      hfp_token_t t;
      t.kind      = cur_kind;
      t.item      = it;
      t.value     = val;
      t.huffman   = huff;
      t.data_byte = data;
      t.last      = lst;
      t.error     = err;
      return t;
    endfunction

    // A prefixed integer is complete: emit its token and move on.
    function hfp_token_t finish_integer(logic [31:0] v);
      hfp_token_t t;
      if (parse_phase == PH_START || parse_phase == PH_IDX_CONT) begin
        if (cur_kind == KIND_INDEXED || cur_kind == KIND_SIZE_UPDATE) begin
          parse_phase = PH_START;
          t = make_token(ITEM_INDEX, v, 1'b0, 8'h00, 1'b1, ERR_NONE);
        end else begin
          // A literal with name index zero carries its own name string.
          parse_phase = (v == 32'd0) ? PH_NLEN_FIRST : PH_VLEN_FIRST;
          t = make_token(ITEM_INDEX, v, 1'b0, 8'h00, 1'b0, ERR_NONE);
        end
        return t;
      end
      bytes_left = v;
      if (parse_phase == PH_NLEN_FIRST || parse_phase == PH_NLEN_CONT) begin
        t = make_token(ITEM_NAME_LEN, v, str_huffman, 8'h00, 1'b0, ERR_NONE);
        parse_phase = (v != 32'd0) ? PH_NAME_DATA : PH_VLEN_FIRST;
      end else begin
        t = make_token(ITEM_VALUE_LEN, v, str_huffman, 8'h00, v == 32'd0, ERR_NONE);
        parse_phase = (v != 32'd0) ? PH_VALUE_DATA : PH_START;
      end
      return t;
    endfunction

    // Advance the shadow parser by one accepted byte.
    function void take_byte(logic [7:0] b, logic blk_end);
      hfp_token_t  tok;
      bit          have;
      bit          overflow;
      int          prefix_bits;
      logic [31:0] mask;
      logic [31:0] v;
      logic [63:0] chunk;
      logic [63:0] sum;
      have = 1'b0;

      // After an overflow everything up to the block end is discarded.
      if (dropping) begin
        bytes_dropped++;
        if (blk_end) begin
          dropping    = 1'b0;
          parse_phase = PH_START;
        end
        return;
      end
      bytes_parsed++;

      case (parse_phase)
        PH_START: begin
          if (b[7]) begin
            cur_kind = KIND_INDEXED;
            prefix_bits = 7;
          end else if (b[6]) begin
            cur_kind = KIND_INCREMENTAL;
            prefix_bits = 6;
          end else if (b[5]) begin
            cur_kind = KIND_SIZE_UPDATE;
            prefix_bits = 5;
          end else if (b[4]) begin
            cur_kind = KIND_NEVER_IDX;
            prefix_bits = 4;
          end else begin
            cur_kind = KIND_WITHOUT_IDX;
            prefix_bits = 4;
          end
          mask = (32'd1 << prefix_bits) - 32'd1;
          v = {24'd0, b} & mask;
          if (v < mask) begin
            tok  = finish_integer(v);
            have = 1'b1;
          end else begin
            accum       = mask;
            shift_cnt   = '0;
            parse_phase = PH_IDX_CONT;
          end
        end
        PH_NLEN_FIRST, PH_VLEN_FIRST: begin
          str_huffman = b[7];
          v = {25'd0, b[6:0]};
          if (v < 32'h7f) begin
            tok  = finish_integer(v);
            have = 1'b1;
          end else begin
            accum       = 32'h7f;
            shift_cnt   = '0;
            parse_phase = phase_t'(parse_phase + 3'd1);
          end
        end
        PH_IDX_CONT, PH_NLEN_CONT, PH_VLEN_CONT: begin
          // Zero groups never overflow, whatever the shift count.
          chunk    = {57'd0, b[6:0]};
          overflow = 1'b0;
          if (chunk != 64'd0) begin
            if (shift_cnt >= 6'd32) begin
              overflow = 1'b1;
            end else begin
              sum = {32'd0, accum} + (chunk << shift_cnt);
              if (sum > 64'h0000_0000_ffff_ffff) overflow = 1'b1;
              else accum = sum[31:0];
            end
          end
          if (overflow) begin
            expected_tokens.push_back(make_token(ITEM_ERROR, 32'd0, 1'b0, 8'h00,
                                                 1'b1, ERR_OVERFLOW));
            overflow_tokens++;
            parse_phase = PH_START;
            if (!blk_end) dropping = 1'b1;
            return;
          end
          if (!b[7]) begin
            tok  = finish_integer(accum);
            have = 1'b1;
          end else if (int'(shift_cnt) + 7 > 63) begin
            shift_cnt = 6'd63;
          end else begin
            shift_cnt = shift_cnt + 6'd7;
          end
        end
        PH_NAME_DATA: begin
          if (bytes_left != 32'd0) bytes_left--;
          tok  = make_token(ITEM_NAME_BYTE, 32'd0, 1'b0, b, 1'b0, ERR_NONE);
          have = 1'b1;
          if (bytes_left == 32'd0) parse_phase = PH_VLEN_FIRST;
        end
        default: begin
          if (bytes_left != 32'd0) bytes_left--;
          tok  = make_token(ITEM_VALUE_BYTE, 32'd0, 1'b0, b, bytes_left == 32'd0,
                            ERR_NONE);
          have = 1'b1;
          if (bytes_left == 32'd0) parse_phase = PH_START;
        end
      endcase

      // A block that ends inside a representation replaces the token.
      if (blk_end && parse_phase != PH_START) begin
        tok  = make_token(ITEM_ERROR, 32'd0, 1'b0, 8'h00, 1'b1, ERR_TRUNC);
        have = 1'b1;
        trunc_tokens++;
        parse_phase = PH_START;
      end
      if (have) expected_tokens.push_back(tok);
    endfunction

    function string token_text(hfp_token_t t);
      return $sformatf("kind=%0d item=%0d value=%h huff=%b data=%h last=%b err=%0d",
                       t.kind, t.item, t.value, t.huffman, t.data_byte, t.last,
                       t.error);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    // Compare one output token with the oldest prediction.
    function void check_token(hfp_token_t got);
      hfp_token_t want;
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        note_failure($sformatf("token %0d with none predicted: got %s",
                               tokens_checked, token_text(got)));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.item !== want.item ||
          got.value !== want.value || got.huffman !== want.huffman ||
          got.data_byte !== want.data_byte || got.last !== want.last ||
          got.error !== want.error) begin
        note_failure($sformatf("token %0d: expected %s, got %s", tokens_checked,
                               token_text(want), token_text(got)));
      end
    endfunction

  endclass

endpackage

// File: test/hpack_field_representation_parser_test.sv
// ---------------------------------------------------------------------------
// HPACK field parser regression
// Streams directed and random header blocks through the parser with random
// idling on both channels and checks every token against a predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpack_field_representation_parser_test;

  import hfp_pkg::*;
  import hfp_token_scoreboard_pkg::*;

  localparam int RANDOM_BYTES = 1050;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_req;
  logic        in_block_end;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [2:0]  out_item;
  logic [31:0] out_value;
  logic        out_huffman;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic [1:0]  out_error;

  token_scoreboard sb = new();
  hfp_byte_t       stream_q[$];
  hfp_token_t      seen_token;
  int              idle_cycles = 0;
  int              long_holds = 0;

  hpack_field_representation_parser u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_req   (in_byte_req),
    .in_block_end  (in_block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_item      (out_item),
    .out_value     (out_value),
    .out_huffman   (out_huffman),
    .out_data_byte (out_data_byte),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  always #4 clk = ~clk;

  // Header block construction.
  task automatic push_byte(logic [7:0] b);
    hfp_byte_t e;
    e.byte_req  = b;
    e.block_end = 1'b0;
    stream_q.push_back(e);
  endtask

  task automatic close_block();
    hfp_byte_t e;
    e = stream_q.pop_back();
    e.block_end = 1'b1;
    stream_q.push_back(e);
  endtask

  // Prefixed integer, optionally padded with zero continuation groups.
  task automatic push_int(logic [7:0] head, int prefix_bits, logic [31:0] value,
                          int zero_groups);
    logic [31:0] mask;
    logic [31:0] rem;
    mask = (32'd1 << prefix_bits) - 32'd1;
    if (value < mask) begin
      push_byte(head | value[7:0]);
      return;
    end
    push_byte(head | mask[7:0]);
    rem = value - mask;
    while (rem >= 32'd128) begin
      push_byte({1'b1, rem[6:0]});
      rem = rem >> 7;
    end
    if (zero_groups == 0) begin
      push_byte({1'b0, rem[6:0]});
    end else begin
      push_byte({1'b1, rem[6:0]});
      repeat (zero_groups - 1) push_byte(8'h80);
      push_byte(8'h00);
    end
  endtask

  function automatic int pick_padding();
    return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 12)) : 0;
  endfunction

  function automatic logic [31:0] pick_integer(int prefix_bits);
    logic [31:0] mask;
    mask = (32'd1 << prefix_bits) - 32'd1;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, mask - 1);
      3, 4:    return mask + $urandom_range(0, 200);
      5:       return $urandom_range(0, 20000);
      6, 7:    return $urandom();
      8:       return 32'hffff_ffff;
      default: return mask;
    endcase
  endfunction

  // Mostly short strings, now and then one with a multi-byte length.
  function automatic int pick_length();
    return ($urandom_range(0, 29) == 0) ? int'($urandom_range(127, 135))
                                        : int'($urandom_range(0, 6));
  endfunction

  task automatic push_string(int len, int n_bytes);
    push_int({1'($urandom_range(0, 1)), 7'd0}, 7, len, pick_padding());
    repeat (n_bytes) push_byte(8'($urandom()));
  endtask

  task automatic pick_literal_head(output logic [7:0] head, output int prefix_bits);
    case ($urandom_range(0, 2))
      0: begin
        head = 8'h40;
        prefix_bits = 6;
      end
      1: begin
        head = 8'h00;
        prefix_bits = 4;
      end
      default: begin
        head = 8'h10;
        prefix_bits = 4;
      end
    endcase
  endtask

  task automatic push_representation();
    logic [7:0]  head;
    int          prefix_bits;
    int          len;
    logic [31:0] name_idx;
    case ($urandom_range(0, 4))
      0: push_int(8'h80, 7, pick_integer(7), pick_padding());
      1: push_int(8'h20, 5, pick_integer(5), pick_padding());
      default: begin
        pick_literal_head(head, prefix_bits);
        name_idx = ($urandom_range(0, 2) == 0) ? 32'd0 : pick_integer(prefix_bits);
        push_int(head, prefix_bits, name_idx, pick_padding());
        if (name_idx == 32'd0) begin
          len = pick_length();
          push_string(len, len);
        end
        len = pick_length();
        push_string(len, len);
      end
    endcase
  endtask

  // An integer that cannot fit in 32 bits, by value or by shift count.
  task automatic push_overflow(logic [7:0] head, int prefix_bits);
    logic [7:0] mask;
    mask = 8'((32'd1 << prefix_bits) - 32'd1);
    push_byte(head | mask);
    if ($urandom_range(0, 1) == 0) begin
      repeat (4) push_byte(8'h80 | 8'($urandom_range(0, 127)));
      push_byte({1'($urandom_range(0, 1)), 7'($urandom_range(16, 127))});
    end else begin
      repeat ($urandom_range(5, 10)) push_byte(8'h80);
      push_byte({1'($urandom_range(0, 1)), 7'($urandom_range(1, 127))});
    end
  endtask

  task automatic build_random_block();
    int         sel;
    int         keep;
    int         prefix_bits;
    logic [7:0] head;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      // Well-formed block, a fraction of them cut short.
      repeat ($urandom_range(1, 3)) push_representation();
      if (sel >= 70) begin
        keep = $urandom_range(1, stream_q.size());
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
    end else if (sel < 88) begin
      if ($urandom_range(0, 1) == 0) push_representation();
      case ($urandom_range(0, 5))
        0: push_overflow(8'h80, 7);
        1: push_overflow(8'h20, 5);
        2, 3: begin
          pick_literal_head(head, prefix_bits);
          push_overflow(head, prefix_bits);
        end
        default: begin
          // Value length overflow after a nonzero name index.
          push_byte(8'h41);
          push_overflow({1'($urandom_range(0, 1)), 7'd0}, 7);
        end
      endcase
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom()));
    end else if (sel < 95) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom()));
    end else begin
      // Huge value length that the block ends long before.
      push_byte(8'h41);
      push_string($urandom() | 32'h0001_0000, $urandom_range(0, 3));
    end
    close_block();
  endtask

  // Offer every queued byte, with a random gap before each one unless the stream is sent as a burst.
  task automatic drive_stream();
    hfp_byte_t e;
    bit        burst;
    int        gap;
    burst = ($urandom_range(0, 3) == 0);
    while (stream_q.size() != 0) begin
      e = stream_q.pop_front();
      gap = burst ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid     = 1'b1;
      in_byte_req  = e.byte_req;
      in_block_end = e.block_end;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
  endtask

  // Accepted items on both channels, plus the stall watchdog.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.take_byte(in_byte_req, in_block_end);
    if (rst_n && out_valid && out_ready) begin
      seen_token.kind      = kind_t'(out_kind);
      seen_token.item      = item_t'(out_item);
      seen_token.value     = out_value;
      seen_token.huffman   = out_huffman;
      seen_token.data_byte = out_data_byte;
      seen_token.last      = out_last;
      seen_token.error     = err_t'(out_error);
      sb.check_token(seen_token);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles.", IDLE_LIMIT);
      $display("hpack_field_representation_parser regression: fail");
      $finish;
    end
  end

  // Token receiver: random stalls, quiet stretches and two long hold-offs.
  initial begin
    int gap;
    bit quiet;
    quiet = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ((long_holds == 0 && sb.tokens_checked >= 150) ||
          (long_holds == 1 && sb.tokens_checked >= 700)) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_holds++;
      end
      if ($urandom_range(0, 31) == 0) quiet = !quiet;
      gap = quiet ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Reset, directed blocks, random blocks, drain and verdict.
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte_req  = 8'h00;
    in_block_end = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Indexed field with index zero.
    push_byte(8'h80);
    close_block();
    // Table size update to the largest 32-bit value.
    push_int(8'h20, 5, 32'hffff_ffff, 0);
    close_block();
    // Incremental literal with a Huffman name string and an empty value.
    push_byte(8'h40);
    push_byte(8'h81);
    push_byte(8'h61);
    push_byte(8'h00);
    close_block();
    // Never-indexed literal with a name index and a two-byte value.
    push_byte(8'h15);
    push_byte(8'h02);
    push_byte(8'hff);
    push_byte(8'h00);
    close_block();
    // Literal without indexing, empty Huffman value.
    push_byte(8'h02);
    push_byte(8'h80);
    close_block();
    // Index overflow, then one dropped byte that ends the block.
    push_byte(8'hff);
    repeat (5) push_byte(8'hff);
    push_byte(8'haa);
    close_block();
    // Block that ends right after the first byte of a literal.
    push_byte(8'h40);
    close_block();
    drive_stream();

    while (sb.bytes_parsed < RANDOM_BYTES) begin
      build_random_block();
      drive_stream();
    end
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d parsed bytes and %0d dropped after overflow, %0d tokens.",
             sb.bytes_parsed, sb.bytes_dropped, sb.tokens_checked);
    $display("Error tokens: %0d overflow, %0d truncation; %0d long receiver hold-offs.",
             sb.overflow_tokens, sb.trunc_tokens, long_holds);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("hpack_field_representation_parser regression: pass");
    end else begin
      $display("%0d failures, %0d tokens still predicted.", sb.mismatches, sb.pending());
      $display("hpack_field_representation_parser regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/hfp_pkg.sv
design/hfp_in_stage.sv
design/hfp_decoder.sv
design/hfp_out_reg.sv
design/hpack_field_representation_parser.sv
test/hfp_token_scoreboard_pkg.sv
test/hpack_field_representation_parser_test.sv
